// File: hw/rtl/oqsf_pkg.sv
// Shared constants, codes and control structs of the switch forwarder.
package oqsf_pkg;

	localparam int NUM_PORTS       = 8;
	localparam int QUEUE_DEPTH     = 16;
	localparam int FLOW_TABLE_SIZE = 16;
	localparam int ADDR_TABLE_SIZE = 16;

	localparam int PORT_W  = $clog2(NUM_PORTS);
	localparam int LIM_W   = PORT_W + 1;
	localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int QADDR_W = PORT_W + SLOT_W;
	localparam int QWORDS  = NUM_PORTS * QUEUE_DEPTH;

	localparam int TAG_W   = 16;
	localparam int PROTO_W = 16;
	localparam int FLOW_W  = 32;
	localparam int ADDR_W  = 48;
	localparam int KEY_W   = ADDR_W;

	// Both rule tables share one memory: the top index bit selects the table.
	localparam int RULE_MAX     = (FLOW_TABLE_SIZE > ADDR_TABLE_SIZE) ?
		FLOW_TABLE_SIZE : ADDR_TABLE_SIZE;
	localparam int RIDX_W       = $clog2(RULE_MAX);
	localparam int RSC_W        = RIDX_W + 1;
	localparam int RENT_W       = RIDX_W + 1;
	localparam int RULE_ENTRIES = 2 * (2 ** RIDX_W);

	localparam int QLIM_W   = 5;
	localparam int ACTIVE_W = 4;
	localparam int CFG_W    = 16;
	localparam int CFGI_W   = 2;

	typedef enum logic [1:0] {
		CMD_PKT     = 2'd0,
		CMD_EGRESS  = 2'd1,
		CMD_FLOW_WR = 2'd2,
		CMD_ADDR_WR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_TX       = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_QFULL    = 3'd2,
		ST_NORULE   = 3'd3,
		ST_RULE_OK  = 3'd4,
		ST_TBL_FULL = 3'd5
	} status_t;

	typedef enum logic [CFGI_W-1:0] {
		CFG_PROTO  = 2'd0,
		CFG_QLIMIT = 2'd1,
		CFG_ACTIVE = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BCAST,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_ENQ,
		S_EGR,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              re;
		logic [RENT_W-1:0] ridx;
		logic              we;
		logic              set_valid;
		logic [RENT_W-1:0] widx;
		logic [KEY_W-1:0]  wkey;
		logic [PORT_W-1:0] wport;
	} rule_req_t;

	typedef struct packed {
		logic               re;
		logic [QADDR_W-1:0] raddr;
		logic               we;
		logic [QADDR_W-1:0] waddr;
		logic [TAG_W-1:0]   wdata;
	} q_req_t;

endpackage

// File: hw/rtl/oqsf_if.sv
// Valid/ready channel interfaces for input items and result words.
interface oqsf_item_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [oqsf_pkg::PORT_W-1:0]   port_number;
	logic [oqsf_pkg::TAG_W-1:0]    packet_tag;
	logic                          is_broadcast;
	logic [oqsf_pkg::PROTO_W-1:0]  protocol_id;
	logic [oqsf_pkg::FLOW_W-1:0]   flow_id;
	logic [oqsf_pkg::ADDR_W-1:0]   dest_addr;

	modport source (output valid, command, port_number, packet_tag, is_broadcast,
		protocol_id, flow_id, dest_addr, input ready);
	modport sink (input valid, command, port_number, packet_tag, is_broadcast,
		protocol_id, flow_id, dest_addr, output ready);
endinterface

interface oqsf_result_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [oqsf_pkg::PORT_W-1:0] out_port;
	logic [oqsf_pkg::TAG_W-1:0]  tx_tag;
	logic                        last;

	modport source (output valid, status, out_port, tx_tag, last, input ready);
	modport sink (input valid, status, out_port, tx_tag, last, output ready);
endinterface

// File: hw/rtl/oqsf_queue_ram.sv
// Packet handle storage for all output queues, one QUEUE_DEPTH-word region per port.
module oqsf_queue_ram (
	input  logic                        clk,
	input  oqsf_pkg::q_req_t            req,
	output logic [oqsf_pkg::TAG_W-1:0]  rdata
);
	logic [oqsf_pkg::TAG_W-1:0] mem_q [oqsf_pkg::QWORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end
endmodule

// File: hw/rtl/oqsf_rule_tbl.sv
// Flow and address rule memory with per-entry valid flags.
module oqsf_rule_tbl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  oqsf_pkg::rule_req_t                  req,
	output logic [oqsf_pkg::RULE_ENTRIES-1:0]    vld,
	output logic [oqsf_pkg::KEY_W-1:0]           rd_key,
	output logic [oqsf_pkg::PORT_W-1:0]          rd_port
);
	logic [oqsf_pkg::KEY_W+oqsf_pkg::PORT_W-1:0] mem_q [oqsf_pkg::RULE_ENTRIES];
	logic [oqsf_pkg::RULE_ENTRIES-1:0]           vld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.widx] <= {req.wkey, req.wport};
		end
		if (req.re) begin
			{rd_key, rd_port} <= mem_q[req.ridx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we && req.set_valid) begin
			vld_q[req.widx] <= 1'b1;
		end
	end

	assign vld = vld_q;
endmodule

// File: hw/rtl/output_queued_switch_forwarder_top.sv
// Top level of the output-queued switch forwarder: control sequencer and port state.
//
// One input word is handled at a time; item_in.ready is high only while the
// sequencer is idle, and results leave through a one-word output register so
// the next word can be taken while a result still waits. Per word: an egress
// complete ends in the accept cycle, or, when a queued handle waits, reads it
// from the queue memory and then emits it. A unicast arrival or rule write
// walks the rule memory after the accept cycle, reading and then comparing
// each valid entry and stepping over each empty one, over up to 16 entries per
// table (a collective-protocol miss then walks the address table too), then
// enqueues or reports. A broadcast gives one result word per cycle while the
// output register is free, one per active port other than ingress, stepping
// over the ingress port when it lies below the last target; with no target it
// gives a single no-rule word. Every result word needs the output register
// free, so a stalled sink holds the sequencer. Rule keys and ports live in one
// synchronous memory read one entry per cycle; packet handles live in a second
// memory, NUM_PORTS regions of QUEUE_DEPTH. Queue head, count and busy flags
// are per-port registers. No clearing pass is needed after reset.
module output_queued_switch_forwarder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	oqsf_item_if.sink                     item_in,
	oqsf_result_if.source                 result_out,
	input  logic                          cfg_we,
	input  logic [oqsf_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [oqsf_pkg::CFG_W-1:0]    cfg_data
);
	localparam int PW = oqsf_pkg::PORT_W;
	localparam int LW = oqsf_pkg::LIM_W;
	localparam int CW = oqsf_pkg::CNT_W;
	localparam int SW = oqsf_pkg::SLOT_W;
	localparam int TW = oqsf_pkg::TAG_W;
	localparam int RW = oqsf_pkg::RIDX_W;
	localparam int NP = oqsf_pkg::NUM_PORTS;

	// configuration
	logic [oqsf_pkg::PROTO_W-1:0]  proto_cfg_q;
	logic [oqsf_pkg::QLIM_W-1:0]   qlimit_q;
	logic [oqsf_pkg::ACTIVE_W-1:0] active_q;

	// per-port queue state
	logic [SW-1:0] head_q [NP];
	logic [CW-1:0] cnt_q  [NP];
	logic [NP-1:0] busy_q;

	// sequencer
	oqsf_pkg::state_t state_q, state_d;
	oqsf_pkg::cmd_t   cmd_q;
	logic [PW-1:0]    inport_q;
	logic [TW-1:0]    tag_q;
	logic [oqsf_pkg::FLOW_W-1:0] fid_q;
	logic [oqsf_pkg::ADDR_W-1:0] addr_q;
	logic             tsel_q;          // 0 flow table, 1 address table
	logic [oqsf_pkg::RSC_W-1:0] sc_q;
	logic             free_found_q;
	logic [RW-1:0]    free_idx_q;
	logic [PW-1:0]    tp_q;            // unicast target port
	logic [LW-1:0]    bp_q;            // broadcast port walker
	logic [LW-1:0]    lastp_q;         // final broadcast port
	oqsf_pkg::status_t em_st_q;
	logic [PW-1:0]    em_port_q;
	logic [TW-1:0]    em_tag_q;

	// output register
	logic              ov_q;
	oqsf_pkg::status_t o_st_q;
	logic [PW-1:0]     o_port_q;
	logic [TW-1:0]     o_tag_q;
	logic              o_last_q;

	// memories
	oqsf_pkg::rule_req_t             rreq;
	logic [oqsf_pkg::RULE_ENTRIES-1:0] rvld;
	logic [oqsf_pkg::KEY_W-1:0]      rd_key;
	logic [PW-1:0]                   rd_port;
	oqsf_pkg::q_req_t                qreq;
	logic [TW-1:0]                   q_rdata;

	oqsf_rule_tbl u_rule_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rreq),
		.vld     (rvld),
		.rd_key  (rd_key),
		.rd_port (rd_port)
	);

	oqsf_queue_ram u_queue_ram (
		.clk   (clk),
		.req   (qreq),
		.rdata (q_rdata)
	);

	// ---------------------------------------------------------------- decode
	logic           accept;
	logic           can_emit;
	oqsf_pkg::cmd_t in_cmd;
	logic [CW-1:0]  qlim;
	logic [LW-1:0]  blim, blim_m1, blim_m2, blast;
	logic           bnone;
	logic           in_pmatch;
	logic [PW-1:0]  in_port;

	assign in_cmd   = oqsf_pkg::cmd_t'(item_in.command);
	assign in_port  = item_in.port_number;
	assign accept   = item_in.valid && item_in.ready;
	assign can_emit = !ov_q || result_out.ready;
	assign item_in.ready = (state_q == oqsf_pkg::S_IDLE);

	// Limits above the hardware size behave as the hardware size.
	assign qlim = (32'(qlimit_q) > oqsf_pkg::QUEUE_DEPTH) ?
		CW'(oqsf_pkg::QUEUE_DEPTH) : CW'(qlimit_q);
	assign blim = (32'(active_q) > NP) ? LW'(NP) : LW'(active_q);
	assign blim_m1 = blim - LW'(1);
	assign blim_m2 = blim - LW'(2);
	// Last broadcast target skips the ingress port when it is the top one.
	assign blast = (blim_m1[PW-1:0] != in_port) ? blim_m1 : blim_m2;
	assign bnone = (blim == '0) || ((blim == LW'(1)) && (in_port == '0));
	assign in_pmatch = (item_in.protocol_id == proto_cfg_q);

	// rule scan helpers
	logic [oqsf_pkg::RSC_W-1:0]  scan_lim;
	logic                        scan_done;
	logic [oqsf_pkg::RENT_W-1:0] scan_ent;
	logic [oqsf_pkg::KEY_W-1:0]  scan_key;
	logic                        key_hit;
	logic                        is_wr;

	assign scan_lim  = tsel_q ? oqsf_pkg::RSC_W'(oqsf_pkg::ADDR_TABLE_SIZE) :
		oqsf_pkg::RSC_W'(oqsf_pkg::FLOW_TABLE_SIZE);
	assign scan_done = (sc_q == scan_lim);
	assign scan_ent  = {tsel_q, sc_q[RW-1:0]};
	assign scan_key  = tsel_q ? addr_q : {{(oqsf_pkg::KEY_W-oqsf_pkg::FLOW_W){1'b0}}, fid_q};
	assign key_hit   = (rd_key == scan_key);
	assign is_wr     = (cmd_q == oqsf_pkg::CMD_FLOW_WR) || (cmd_q == oqsf_pkg::CMD_ADDR_WR);

	// --------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oqsf_pkg::S_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						oqsf_pkg::CMD_PKT: begin
							if (item_in.is_broadcast) begin
								state_d = bnone ? oqsf_pkg::S_EMIT : oqsf_pkg::S_BCAST;
							end else begin
								state_d = oqsf_pkg::S_SCAN_RD;
							end
						end
						oqsf_pkg::CMD_EGRESS: begin
							if (cnt_q[in_port] != '0) begin
								state_d = oqsf_pkg::S_EGR;
							end
						end
						default: state_d = oqsf_pkg::S_SCAN_RD;
					endcase
				end
			end
			oqsf_pkg::S_BCAST: begin
				if (bp_q[PW-1:0] != inport_q && can_emit && bp_q == lastp_q) begin
					state_d = oqsf_pkg::S_IDLE;
				end
			end
			oqsf_pkg::S_SCAN_RD: begin
				if (scan_done) begin
					if (!(cmd_q == oqsf_pkg::CMD_PKT && !tsel_q)) begin
						state_d = oqsf_pkg::S_EMIT;
					end
				end else if (rvld[scan_ent]) begin
					state_d = oqsf_pkg::S_SCAN_CMP;
				end
			end
			oqsf_pkg::S_SCAN_CMP: begin
				if (!key_hit) begin
					state_d = oqsf_pkg::S_SCAN_RD;
				end else if (is_wr) begin
					state_d = oqsf_pkg::S_EMIT;
				end else if (tsel_q || rd_port != inport_q) begin
					state_d = oqsf_pkg::S_ENQ;
				end else begin
					state_d = oqsf_pkg::S_SCAN_RD;
				end
			end
			oqsf_pkg::S_ENQ,
			oqsf_pkg::S_EGR,
			oqsf_pkg::S_EMIT: begin
				if (can_emit) begin
					state_d = oqsf_pkg::S_IDLE;
				end
			end
			default: state_d = oqsf_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------ outputs / control
	logic              enq_do;
	logic [PW-1:0]     enq_p;
	logic              enq_full;
	logic              emit;
	oqsf_pkg::status_t emit_st;
	logic [PW-1:0]     emit_port;
	logic [TW-1:0]     emit_tag;
	logic              emit_last;
	logic              egr_pop;

	always_comb begin
		enq_do    = 1'b0;
		enq_p     = tp_q;
		emit      = 1'b0;
		emit_st   = oqsf_pkg::ST_TX;
		emit_port = tp_q;
		emit_tag  = tag_q;
		emit_last = 1'b1;
		egr_pop   = 1'b0;
		rreq      = '0;
		qreq      = '0;
		unique case (state_q)
			oqsf_pkg::S_IDLE: begin
				if (accept && in_cmd == oqsf_pkg::CMD_EGRESS) begin
					qreq.re    = 1'b1;
					qreq.raddr = {in_port, head_q[in_port]};
				end
			end
			oqsf_pkg::S_BCAST: begin
				enq_p = bp_q[PW-1:0];
				if (bp_q[PW-1:0] != inport_q && can_emit) begin
					enq_do    = 1'b1;
					emit      = 1'b1;
					emit_last = (bp_q == lastp_q);
				end
			end
			oqsf_pkg::S_SCAN_RD: begin
				if (scan_done) begin
					if (is_wr && free_found_q) begin
						rreq.we        = 1'b1;
						rreq.set_valid = 1'b1;
						rreq.widx      = {tsel_q, free_idx_q};
						rreq.wkey      = scan_key;
						rreq.wport     = inport_q;
					end
				end else if (rvld[scan_ent]) begin
					rreq.re   = 1'b1;
					rreq.ridx = scan_ent;
				end
			end
			oqsf_pkg::S_SCAN_CMP: begin
				if (key_hit && is_wr) begin
					rreq.we    = 1'b1;
					rreq.widx  = scan_ent;
					rreq.wkey  = scan_key;
					rreq.wport = inport_q;
				end
			end
			oqsf_pkg::S_ENQ: begin
				if (can_emit) begin
					enq_do = 1'b1;
					emit   = 1'b1;
				end
			end
			oqsf_pkg::S_EGR: begin
				if (can_emit) begin
					egr_pop   = 1'b1;
					emit      = 1'b1;
					emit_st   = oqsf_pkg::ST_TX;
					emit_port = inport_q;
					emit_tag  = q_rdata;
				end
			end
			oqsf_pkg::S_EMIT: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_st   = em_st_q;
					emit_port = em_port_q;
					emit_tag  = em_tag_q;
				end
			end
			default: ;
		endcase

		// Enqueue outcome; an idle port always has an empty queue, so an arriving
		// handle that is not refused as full goes straight out.
		enq_full = (cnt_q[enq_p] >= qlim);
		if (enq_do) begin
			emit_port = enq_p;
			emit_tag  = tag_q;
			if (enq_full) begin
				emit_st = oqsf_pkg::ST_QFULL;
			end else if (busy_q[enq_p]) begin
				emit_st    = oqsf_pkg::ST_QUEUED;
				qreq.we    = 1'b1;
				qreq.waddr = {enq_p, head_q[enq_p] + cnt_q[enq_p][SW-1:0]};
				qreq.wdata = tag_q;
			end else begin
				emit_st = oqsf_pkg::ST_TX;
			end
		end
	end

	// ----------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oqsf_pkg::S_IDLE;
			proto_cfg_q <= '0;
			qlimit_q    <= oqsf_pkg::QLIM_W'(16);
			active_q    <= oqsf_pkg::ACTIVE_W'(8);
			ov_q        <= 1'b0;
			busy_q      <= '0;
			for (int i = 0; i < NP; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (oqsf_pkg::cfg_idx_t'(cfg_index))
					oqsf_pkg::CFG_PROTO:  proto_cfg_q <= cfg_data;
					oqsf_pkg::CFG_QLIMIT: qlimit_q <= cfg_data[oqsf_pkg::QLIM_W-1:0];
					oqsf_pkg::CFG_ACTIVE: active_q <= cfg_data[oqsf_pkg::ACTIVE_W-1:0];
					default: ;
				endcase
			end

			if (emit) begin
				ov_q <= 1'b1;
			end else if (result_out.ready) begin
				ov_q <= 1'b0;
			end

			// port state
			if (state_q == oqsf_pkg::S_IDLE && accept && in_cmd == oqsf_pkg::CMD_EGRESS) begin
				busy_q[in_port] <= 1'b0;
			end
			if (egr_pop) begin
				head_q[inport_q] <= head_q[inport_q] + SW'(1);
				cnt_q[inport_q]  <= cnt_q[inport_q] - CW'(1);
				busy_q[inport_q] <= 1'b1;
			end
			if (enq_do && !enq_full) begin
				if (busy_q[enq_p]) begin
					cnt_q[enq_p] <= cnt_q[enq_p] + CW'(1);
				end else begin
					head_q[enq_p] <= head_q[enq_p] + SW'(1);
					busy_q[enq_p] <= 1'b1;
				end
			end
		end
	end

	// payload and walker registers
	always_ff @(posedge clk) begin
		if (emit) begin
			o_st_q   <= emit_st;
			o_port_q <= emit_port;
			o_tag_q  <= emit_tag;
			o_last_q <= emit_last;
		end

		unique case (state_q)
			oqsf_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q        <= in_cmd;
					inport_q     <= in_port;
					tag_q        <= item_in.packet_tag;
					fid_q        <= item_in.flow_id;
					addr_q       <= item_in.dest_addr;
					sc_q         <= '0;
					free_found_q <= 1'b0;
					bp_q         <= '0;
					lastp_q      <= blast;
					tsel_q       <= !((in_cmd == oqsf_pkg::CMD_PKT && in_pmatch) ||
						in_cmd == oqsf_pkg::CMD_FLOW_WR);
					em_st_q      <= oqsf_pkg::ST_NORULE;
					em_port_q    <= in_port;
					em_tag_q     <= item_in.packet_tag;
				end
			end
			oqsf_pkg::S_BCAST: begin
				if (bp_q[PW-1:0] == inport_q || can_emit) begin
					bp_q <= bp_q + LW'(1);
				end
			end
			oqsf_pkg::S_SCAN_RD: begin
				if (scan_done) begin
					if (cmd_q == oqsf_pkg::CMD_PKT && !tsel_q) begin
						tsel_q <= 1'b1;
						sc_q   <= '0;
					end else if (is_wr) begin
						em_st_q  <= free_found_q ? oqsf_pkg::ST_RULE_OK :
							oqsf_pkg::ST_TBL_FULL;
						em_tag_q <= '0;
					end
				end else if (!rvld[scan_ent]) begin
					sc_q <= sc_q + oqsf_pkg::RSC_W'(1);
					if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= sc_q[RW-1:0];
					end
				end
			end
			oqsf_pkg::S_SCAN_CMP: begin
				tp_q <= rd_port;
				if (!key_hit) begin
					sc_q <= sc_q + oqsf_pkg::RSC_W'(1);
				end else if (is_wr) begin
					em_st_q  <= oqsf_pkg::ST_RULE_OK;
					em_tag_q <= '0;
				end else if (!tsel_q && rd_port == inport_q) begin
					// flow rule points back at ingress: fall through to addresses
					tsel_q <= 1'b1;
					sc_q   <= '0;
				end
			end
			default: ;
		endcase
	end

	assign result_out.valid    = ov_q;
	assign result_out.status   = o_st_q;
	assign result_out.out_port = o_port_q;
	assign result_out.tx_tag   = o_tag_q;
	assign result_out.last     = o_last_q;
endmodule

// File: verif/oqsf_checker.sv
// Forwarding predictor and result checker for the output-queued switch forwarder.
`timescale 1ns / 1ps
module oqsf_checker
	import oqsf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	oqsf_item_if                item_mon,
	oqsf_result_if              res_mon,
	input  logic                cfg_we,
	input  logic [CFGI_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  errors,
	output int                  pending
);

	typedef struct {
		status_t            status;
		logic [PORT_W-1:0]  port;
		logic [TAG_W-1:0]   tag;
		logic               last;
	} word_t;

	word_t expected_words[$];
	word_t burst[$];

	// model copy of the switch state
	logic [TAG_W-1:0]  qmem [NUM_PORTS][QUEUE_DEPTH];
	int                qhead [NUM_PORTS];
	int                qcnt [NUM_PORTS];
	bit                busy [NUM_PORTS];
	logic [FLOW_W-1:0] fkey [FLOW_TABLE_SIZE];
	int                fport [FLOW_TABLE_SIZE];
	bit                fvalid [FLOW_TABLE_SIZE];
	logic [ADDR_W-1:0] akey [ADDR_TABLE_SIZE];
	int                aport [ADDR_TABLE_SIZE];
	bit                avalid [ADDR_TABLE_SIZE];
	logic [PROTO_W-1:0] coll_proto;
	int                qlimit;
	int                nactive;

	function automatic void note(status_t s, int p, logic [TAG_W-1:0] t);
		word_t w;
		w.status = s;
		w.port = PORT_W'(p);
		w.tag = t;
		w.last = 1'b0;
		burst = {burst, w};
	endfunction

	// dequeue head onto an idle port
	function automatic bit start_tx(int p, output logic [TAG_W-1:0] t);
		if (busy[p] || qcnt[p] == 0)
			return 0;
		t = qmem[p][qhead[p]];
		qhead[p] = (qhead[p] + 1) % QUEUE_DEPTH;
		qcnt[p]--;
		busy[p] = 1;
		return 1;
	endfunction

	function automatic void enqueue_pkt(int p, logic [TAG_W-1:0] t);
		int lim;
		logic [TAG_W-1:0] sent;
		lim = (qlimit > QUEUE_DEPTH) ? QUEUE_DEPTH : qlimit;
		if (qcnt[p] >= lim) begin
			note(ST_QFULL, p, t);
			return;
		end
		qmem[p][(qhead[p] + qcnt[p]) % QUEUE_DEPTH] = t;
		qcnt[p]++;
		if (start_tx(p, sent))
			note(ST_TX, p, sent);
		else
			note(ST_QUEUED, p, t);
	endfunction

	function automatic void route_pkt(int inp, logic [TAG_W-1:0] t, logic bc,
			logic [PROTO_W-1:0] proto, logic [FLOW_W-1:0] fid, logic [ADDR_W-1:0] da);
		int lim;
		if (bc) begin
			lim = (nactive > NUM_PORTS) ? NUM_PORTS : nactive;
			for (int i = 0; i < lim; i++)
				if (i != inp)
					enqueue_pkt(i, t);
			if (burst.size() == 0)
				note(ST_NORULE, inp, t);
			return;
		end
		if (proto == coll_proto) begin
			for (int i = 0; i < FLOW_TABLE_SIZE; i++) begin
				if (fvalid[i] && fkey[i] == fid) begin
					if (fport[i] != inp && fport[i] < NUM_PORTS) begin
						enqueue_pkt(fport[i], t);
						return;
					end
					break;
				end
			end
		end
		for (int i = 0; i < ADDR_TABLE_SIZE; i++) begin
			if (avalid[i] && akey[i] == da) begin
				if (aport[i] < NUM_PORTS)
					enqueue_pkt(aport[i], t);
				else
					note(ST_NORULE, aport[i], t);
				return;
			end
		end
		note(ST_NORULE, inp, t);
	endfunction

	function automatic void learn_flow(logic [FLOW_W-1:0] k, int p);
		int slot;
		slot = -1;
		for (int i = 0; i < FLOW_TABLE_SIZE; i++) begin
			if (fvalid[i] && fkey[i] == k) begin
				fport[i] = p;
				note(ST_RULE_OK, p, '0);
				return;
			end
			if (!fvalid[i] && slot < 0)
				slot = i;
		end
		if (slot < 0) begin
			note(ST_TBL_FULL, p, '0);
			return;
		end
		fvalid[slot] = 1;
		fkey[slot] = k;
		fport[slot] = p;
		note(ST_RULE_OK, p, '0);
	endfunction

	function automatic void learn_addr(logic [ADDR_W-1:0] k, int p);
		int slot;
		slot = -1;
		for (int i = 0; i < ADDR_TABLE_SIZE; i++) begin
			if (avalid[i] && akey[i] == k) begin
				aport[i] = p;
				note(ST_RULE_OK, p, '0);
				return;
			end
			if (!avalid[i] && slot < 0)
				slot = i;
		end
		if (slot < 0) begin
			note(ST_TBL_FULL, p, '0);
			return;
		end
		avalid[slot] = 1;
		akey[slot] = k;
		aport[slot] = p;
		note(ST_RULE_OK, p, '0);
	endfunction

	function automatic void predict_word();
		int p;
		logic [TAG_W-1:0] sent;
		p = item_mon.port_number;
		burst.delete();
		case (cmd_t'(item_mon.command))
			CMD_PKT: route_pkt(p, item_mon.packet_tag, item_mon.is_broadcast,
				item_mon.protocol_id, item_mon.flow_id, item_mon.dest_addr);
			CMD_EGRESS: begin
				busy[p] = 0;
				if (start_tx(p, sent))
					note(ST_TX, p, sent);
			end
			CMD_FLOW_WR: learn_flow(item_mon.flow_id, p);
			default: learn_addr(item_mon.dest_addr, p);
		endcase
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		expected_words = {expected_words, burst};
	endfunction

	function automatic void check_word();
		word_t w;
		if (expected_words.size() == 0) begin
			$error("unexpected result word: status %0d port %0d tag %h",
				res_mon.status, res_mon.out_port, res_mon.tx_tag);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		if (res_mon.status !== w.status) begin
			$error("status: expected %0d actual %0d", w.status, res_mon.status);
			errors++;
		end
		if (res_mon.out_port !== w.port) begin
			$error("out_port: expected %0d actual %0d", w.port, res_mon.out_port);
			errors++;
		end
		if (res_mon.tx_tag !== w.tag) begin
			$error("tx_tag: expected %h actual %h", w.tag, res_mon.tx_tag);
			errors++;
		end
		if (res_mon.last !== w.last) begin
			$error("last: expected %0d actual %0d", w.last, res_mon.last);
			errors++;
		end
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			for (int i = 0; i < NUM_PORTS; i++) begin
				qhead[i] = 0;
				qcnt[i] = 0;
				busy[i] = 0;
			end
			for (int i = 0; i < FLOW_TABLE_SIZE; i++)
				fvalid[i] = 0;
			for (int i = 0; i < ADDR_TABLE_SIZE; i++)
				avalid[i] = 0;
			coll_proto = '0;
			qlimit = 16;
			nactive = 8;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PROTO:  coll_proto = cfg_data[PROTO_W-1:0];
					CFG_QLIMIT: qlimit = int'(cfg_data[QLIM_W-1:0]);
					CFG_ACTIVE: nactive = int'(cfg_data[ACTIVE_W-1:0]);
					default: ;
				endcase
			end
			if (item_mon.valid && item_mon.ready)
				predict_word();
			if (res_mon.valid && res_mon.ready)
				check_word();
		end
		pending = expected_words.size();
	end

endmodule

// File: verif/tb.sv
// Testbench top: stimulus, flow control and verdict for the switch forwarder.
`timescale 1ns / 1ps
module tb;
	import oqsf_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int errors;
	int pending;

	// no idling near the end of the run
	bit quiet;
	int words_sent;
	int settings_used;

	logic [FLOW_W-1:0] flow_pool [24];
	logic [ADDR_W-1:0] addr_pool [24];

	oqsf_item_if   item();
	oqsf_result_if res();

	output_queued_switch_forwarder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item),
		.result_out (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	oqsf_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_mon  (item),
		.res_mon   (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Result sink: ready bursts, then stall bursts, none while quiet.
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			if (!quiet) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(posedge clk);
			end
		end
	end

	// Offer one word and hold it until the handshake edge.
	// Caller sits at a rising edge; ready is sampled mid-cycle.
	task automatic send_word(cmd_t c, logic [PORT_W-1:0] pn, logic [TAG_W-1:0] t,
			logic bc, logic [PROTO_W-1:0] proto, logic [FLOW_W-1:0] fid,
			logic [ADDR_W-1:0] da);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.command <= c;
		item.port_number <= pn;
		item.packet_tag <= t;
		item.is_broadcast <= bc;
		item.protocol_id <= proto;
		item.flow_id <= fid;
		item.dest_addr <= da;
		do @(negedge clk); while (!item.ready);
		@(posedge clk);
		words_sent++;
	endtask

	// Drop valid and wait until the block is drained and quiet.
	// Egress completes on empty queues give no result, hence the tail.
	task automatic drain();
		item.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(logic [15:0] proto, logic [15:0] lim, logic [15:0] act);
		write_reg(CFG_PROTO, proto);
		write_reg(CFG_QLIMIT, lim);
		write_reg(CFG_ACTIVE, act);
		settings_used++;
	endtask

	// One random word. Mostly well-formed traffic against pooled keys so that
	// rules hit, queues fill and drain; a share of full-range noise.
	task automatic random_word(logic [PROTO_W-1:0] proto_sel);
		int pick;
		logic [PORT_W-1:0] pn;
		logic [PROTO_W-1:0] proto;
		logic [FLOW_W-1:0] fid;
		logic [ADDR_W-1:0] da;
		pick = $urandom_range(0, 99);
		pn = PORT_W'($urandom_range(0, NUM_PORTS - 1));
		proto = ($urandom_range(0, 1) != 0) ? proto_sel : PROTO_W'($urandom);
		fid = ($urandom_range(0, 7) != 0) ? flow_pool[$urandom_range(0, 23)] : $urandom;
		da = ($urandom_range(0, 7) != 0) ? addr_pool[$urandom_range(0, 23)]
			: ADDR_W'({$urandom, $urandom});
		if (pick < 35)
			send_word(CMD_PKT, pn, TAG_W'($urandom), 1'b0, proto, fid, da);
		else if (pick < 50)
			send_word(CMD_PKT, ($urandom_range(0, 2) == 0) ? '0 : pn,
				TAG_W'($urandom), 1'b1, proto, fid, da);
		else if (pick < 80)
			send_word(CMD_EGRESS, pn, TAG_W'($urandom), 1'($urandom), proto, fid, da);
		else if (pick < 90)
			send_word(CMD_FLOW_WR, pn, TAG_W'($urandom), 1'($urandom), proto, fid, da);
		else
			send_word(CMD_ADDR_WR, pn, TAG_W'($urandom), 1'($urandom), proto, fid, da);
	endtask

	// Random phases: proto, queue limit, active ports. Extremes included:
	// limit 0 (all full), limit above depth, no active port, active above ports.
	logic [15:0] phase_cfg [6][3] = '{
		'{16'h88b5, 16'd1,  16'd1},
		'{16'hffff, 16'd31, 16'd15},
		'{16'h0000, 16'd0,  16'd0},
		'{16'h1234, 16'd3,  16'd2},
		'{16'h8000, 16'd16, 16'd8},
		'{16'h88b5, 16'd4,  16'd5}
	};

	initial begin
		quiet = 0;
		words_sent = 0;
		settings_used = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.command = '0;
		item.port_number = '0;
		item.packet_tag = '0;
		item.is_broadcast = 1'b0;
		item.protocol_id = '0;
		item.flow_id = '0;
		item.dest_addr = '0;
		flow_pool[0] = '0;
		flow_pool[1] = '1;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < 24; i++) begin
			flow_pool[i] = $urandom;
			addr_pool[i] = ADDR_W'({$urandom, $urandom});
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset config (proto 0, limit 16, 8 active).
		send_word(CMD_FLOW_WR, 3'd7, '0, 1'b0, '0, '1, '0);          // max key
		send_word(CMD_FLOW_WR, 3'd0, '0, 1'b0, '0, '0, '0);          // zero key
		send_word(CMD_FLOW_WR, 3'd5, '0, 1'b0, '0, '1, '0);          // overwrite
		send_word(CMD_ADDR_WR, 3'd1, '0, 1'b0, '0, '0, '0);
		send_word(CMD_ADDR_WR, 3'd7, '0, 1'b0, '0, '0, '1);
		send_word(CMD_ADDR_WR, 3'd2, '0, 1'b0, '0, '0, 48'h0000_0000_0001);
		send_word(CMD_PKT, 3'd0, 16'hffff, 1'b1, '1, '1, '1);        // broadcast
		send_word(CMD_PKT, 3'd7, 16'h0001, 1'b1, '0, '0, '0);        // broadcast, port 7 in
		send_word(CMD_PKT, 3'd3, 16'h1111, 1'b0, '0, '1, '0);        // flow hit -> 5
		send_word(CMD_PKT, 3'd0, 16'h2222, 1'b0, '0, '0, '1);        // flow on ingress -> addr
		send_word(CMD_PKT, 3'd4, 16'h3333, 1'b0, 16'h0800, '1, '1);  // proto miss -> addr 7
		send_word(CMD_PKT, 3'd4, 16'h4444, 1'b0, 16'h0800, '0, 48'h5); // no rule
		send_word(CMD_EGRESS, 3'd7, '0, 1'b0, '0, '0, '0);
		send_word(CMD_EGRESS, 3'd7, '0, 1'b0, '0, '0, '0);
		send_word(CMD_EGRESS, 3'd6, '0, 1'b0, '0, '0, '0);
		send_word(CMD_EGRESS, 3'd6, '0, 1'b0, '0, '0, '0);           // empty queue
		send_word(CMD_PKT, 3'd2, 16'h0000, 1'b0, '0, 32'h5, 48'h1);
		drain();
		// broadcast with no target: only the ingress port is active
		apply_setting(16'h0000, 16'd1, 16'd1);
		send_word(CMD_PKT, 3'd0, 16'habcd, 1'b1, '0, '0, '0);
		send_word(CMD_PKT, 3'd2, 16'h5555, 1'b0, '0, '0, 48'h1);     // flow hit -> 0, queued under limit 1
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			apply_setting(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
			if (ph == 5)
				quiet = 1;
			for (int n = 0; n < 60; n++)
				random_word(phase_cfg[ph][0]);
			drain();
		end

		$display("Sent %0d words over %0d register settings, rule tables driven to full.",
			words_sent, settings_used + 1);
		$display("Errors: %0d", errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
